>>> hdl/kdt_pkg.sv
// ----------------------------------------------------------------------------
// kdt_pkg
// Shared types and constants of the key double-tap detector.
// ----------------------------------------------------------------------------
package kdt_pkg;

    localparam int KEY_W   = 16;
    localparam int SCAN_W  = 16;
    localparam int MOD_W   = 5;
    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_ENABLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_WINDOW_MS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW_MS = 2'd2;

    localparam logic [WIN_W-1:0] DOUBLE_WINDOW_RESET = 16'd300;

    localparam logic KIND_KEY   = 1'b0;
    localparam logic KIND_TICK  = 1'b1;
    localparam logic TAP_SINGLE = 1'b0;
    localparam logic TAP_DOUBLE = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]  virtual_key;
        logic [SCAN_W-1:0] scan_code;
        logic [MOD_W-1:0]  modifier_bits;
    } t_ident;

    typedef struct packed {
        logic              kind;
        logic [KEY_W-1:0]  virtual_key;
        logic [SCAN_W-1:0] scan_code;
        logic [MOD_W-1:0]  modifier_bits;
    } t_in_req;

    typedef struct packed {
        logic              tap_type;
        logic [KEY_W-1:0]  out_key;
        logic [SCAN_W-1:0] out_scan;
        logic [MOD_W-1:0]  out_modifiers;
        logic [TIME_W-1:0] interval_ms;
    } t_out_req;

    typedef struct packed {
        logic              search;
        logic              push;
        t_ident            ident;
        logic [TIME_W-1:0] stamp;
    } t_hist_cmd;

    typedef struct packed {
        logic              done;
        logic              found;
        logic [TIME_W-1:0] stamp;
    } t_hist_sts;

endpackage

>>> hdl/kdt_hist.sv
// ----------------------------------------------------------------------------
// kdt_hist
// Tap history ring in a synchronous memory with a newest-first search engine
// that reads one entry per cycle, and the push logic with overflow trimming.
// ----------------------------------------------------------------------------
module kdt_hist #(
    parameter int DEPTH = 256,
    parameter int TRIM  = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  kdt_pkg::t_hist_cmd i_cmd,
    output kdt_pkg::t_hist_sts o_sts
);
    import kdt_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam bit            TRIM_ALL   = (TRIM >= DEPTH);
    localparam logic [CW-1:0] TRIM_COUNT = TRIM_ALL ? '0 : CW'(TRIM);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);

    typedef struct packed {
        t_ident            ident;
        logic [TIME_W-1:0] stamp;
    } t_entry;

    t_entry            mem [DEPTH];
    t_entry            r_rd_data;
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_addr;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     r_k;
    logic              r_busy;
    logic              r_done;
    logic              r_found;
    logic [TIME_W-1:0] r_stamp;
    t_ident            r_ident;
    logic [AW-1:0]     w_start_addr;
    logic [AW-1:0]     w_rd_addr;
    logic [CW-1:0]     w_base;

    function automatic logic [AW-1:0] prev_addr(input logic [AW-1:0] a);
        return (a == '0) ? LAST_ADDR : a - 1'b1;
    endfunction

    always_comb begin
        w_start_addr = prev_addr(r_head);
        w_rd_addr    = r_busy ? r_addr : w_start_addr;
        if (r_count == FULL_COUNT) begin
            w_base = TRIM_ALL ? '0 : r_count - TRIM_COUNT;
        end else begin
            w_base = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            mem[r_head] <= '{ident: i_cmd.ident, stamp: i_cmd.stamp};
        end
        r_rd_data <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.push) begin
                r_head  <= (r_head == LAST_ADDR) ? '0 : r_head + 1'b1;
                r_count <= w_base + 1'b1;
            end
            if (i_cmd.search) begin
                r_ident <= i_cmd.ident;
                r_found <= 1'b0;
                if (r_count == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_k    <= CW'(1);
                    r_addr <= prev_addr(w_start_addr);
                end
            end else if (r_busy) begin
                if (r_rd_data.ident == r_ident) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b1;
                    r_stamp <= r_rd_data.stamp;
                end else if (r_k == r_count) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k    <= r_k + 1'b1;
                    r_addr <= prev_addr(r_addr);
                end
            end
        end
    end

    assign o_sts = '{done: r_done, found: r_found, stamp: r_stamp};

endmodule

>>> hdl/key_double_tap_detector.sv
// ----------------------------------------------------------------------------
// key_double_tap_detector
// Reports single and double key taps from key-down and millisecond tick
// requests, in immediate history mode or in held pending-tap mode.
// ----------------------------------------------------------------------------
// A tick request and a key request in delay mode each pass through one state,
// S_TICK or S_DELAY, on the way back to idle. A key request in immediate mode
// passes through S_SEARCH, where the single read port of the history memory
// is scanned newest first one entry per cycle, up to every entry held, and
// then through S_JUDGE. A finished result waits in an output register, and
// only a new result stalls while that register is still occupied.
module key_double_tap_detector #(
    parameter int HISTORY_DEPTH = 256,
    parameter int HISTORY_TRIM  = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  kdt_pkg::t_in_req                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output kdt_pkg::t_out_req                   o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [kdt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [kdt_pkg::WIN_W-1:0]           i_cfg_data
);
    import kdt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DELAY,
        S_SEARCH,
        S_JUDGE
    } t_state;

    t_state            r_state;
    logic              r_delay_en;
    logic [WIN_W-1:0]  r_delay_win;
    logic [WIN_W-1:0]  r_double_win;
    logic [TIME_W-1:0] r_now;
    t_ident            r_ident;
    logic              r_pend_valid;
    t_ident            r_pend_ident;
    logic [TIME_W-1:0] r_pend_stamp;
    t_hist_cmd         r_cmd;
    t_hist_sts         w_sts;
    logic              r_out_valid;
    t_out_req          r_out;
    logic              w_out_free;
    logic [TIME_W-1:0] w_pend_gap;
    logic [TIME_W-1:0] w_hist_gap;
    logic              w_pend_expired;
    logic              w_pend_repeat;
    logic              w_hist_double;

    function automatic t_out_req make_out(input logic tap, input t_ident id,
                                          input logic [TIME_W-1:0] gap);
        t_out_req o;
        o.tap_type      = tap;
        o.out_key       = id.virtual_key;
        o.out_scan      = id.scan_code;
        o.out_modifiers = id.modifier_bits;
        o.interval_ms   = gap;
        return o;
    endfunction

    kdt_hist #(
        .DEPTH(HISTORY_DEPTH),
        .TRIM (HISTORY_TRIM)
    ) u_hist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (r_cmd),
        .o_sts  (w_sts)
    );

    always_comb begin
        w_out_free     = !r_out_valid || i_out_ready;
        w_pend_gap     = r_now - r_pend_stamp;
        w_hist_gap     = r_now - w_sts.stamp;
        w_pend_expired = r_pend_valid && (w_pend_gap >= TIME_W'(r_delay_win));
        w_pend_repeat  = !w_pend_expired && (r_pend_ident == r_ident)
                         && (w_pend_gap <= TIME_W'(r_delay_win));
        w_hist_double  = w_sts.found && (w_hist_gap <= TIME_W'(r_double_win));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_delay_en   <= 1'b0;
            r_delay_win  <= '0;
            r_double_win <= DOUBLE_WINDOW_RESET;
            r_now        <= '0;
            r_pend_valid <= 1'b0;
            r_pend_ident <= '0;
            r_pend_stamp <= '0;
            r_cmd        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_cmd.search <= 1'b0;
            r_cmd.push   <= 1'b0;
            if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DELAY_ENABLE:     r_delay_en   <= i_cfg_data[0];
                    CFG_DELAY_WINDOW_MS:  r_delay_win  <= i_cfg_data;
                    CFG_DOUBLE_WINDOW_MS: r_double_win <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ident <= '{virtual_key:   i_in.virtual_key,
                                     scan_code:     i_in.scan_code,
                                     modifier_bits: i_in.modifier_bits};
                        if (i_in.kind == KIND_TICK) begin
                            r_now   <= r_now + 1'b1;
                            r_state <= S_TICK;
                        end else if (r_delay_en) begin
                            r_state <= S_DELAY;
                        end else begin
                            r_cmd.search <= 1'b1;
                            r_cmd.ident  <= '{virtual_key:   i_in.virtual_key,
                                              scan_code:     i_in.scan_code,
                                              modifier_bits: i_in.modifier_bits};
                            r_state      <= S_SEARCH;
                        end
                    end
                end
                S_TICK: begin
                    if (r_delay_en && w_pend_expired) begin
                        if (w_out_free) begin
                            r_out        <= make_out(TAP_SINGLE, r_pend_ident, '0);
                            r_out_valid  <= 1'b1;
                            r_pend_valid <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DELAY: begin
                    if (!r_pend_valid || w_out_free) begin
                        if (!r_pend_valid) begin
                            r_pend_valid <= 1'b1;
                            r_pend_ident <= r_ident;
                            r_pend_stamp <= r_now;
                        end else if (w_pend_repeat) begin
                            r_out        <= make_out(TAP_DOUBLE, r_ident, w_pend_gap);
                            r_out_valid  <= 1'b1;
                            r_pend_valid <= 1'b0;
                        end else begin
                            r_out        <= make_out(TAP_SINGLE, r_pend_ident, '0);
                            r_out_valid  <= 1'b1;
                            r_pend_ident <= r_ident;
                            r_pend_stamp <= r_now;
                        end
                        r_cmd.push  <= 1'b1;
                        r_cmd.ident <= r_ident;
                        r_cmd.stamp <= r_now;
                        r_state     <= S_IDLE;
                    end
                end
                S_SEARCH: begin
                    if (w_sts.done) begin
                        r_state <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    if (w_out_free) begin
                        if (w_hist_double) begin
                            r_out <= make_out(TAP_DOUBLE, r_ident, w_hist_gap);
                        end else begin
                            r_out <= make_out(TAP_SINGLE, r_ident, '0);
                        end
                        r_out_valid <= 1'b1;
                        r_cmd.push  <= 1'b1;
                        r_cmd.ident <= r_ident;
                        r_cmd.stamp <= r_now;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the key double-tap detector against a tap predictor kept in step
// with every accepted request and register write. A short table of directed
// requests comes first, followed by random phases in both modes, with random
// gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module testbench;

    import kdt_pkg::*;

    localparam int HDEPTH      = 256;
    localparam int HTRIM       = 128;
    localparam int SETTLE      = HDEPTH + 8;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 235;

    localparam t_in_req KEY_ZERO = {KIND_KEY, 16'h0000, 16'h0000, 5'h00};
    localparam t_in_req KEY_ONES = {KIND_KEY, 16'hffff, 16'hffff, 5'h1f};
    localparam t_in_req KEY_MOD1 = {KIND_KEY, 16'h0000, 16'h0000, 5'h01};
    localparam t_in_req TICK     = {KIND_TICK, 16'h5a5a, 16'ha5a5, 5'h15};

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_index;
        logic [WIN_W-1:0]     cfg_data;
        t_in_req              req;
        bit                   typed;
        t_out_req             want;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_req              i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_req             o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_DELAY_ENABLE;
    logic [WIN_W-1:0]     i_cfg_data  = '0;

    // Predictor state and register copies.
    logic              delay_en   = 1'b0;
    logic [WIN_W-1:0]  delay_win  = '0;
    logic [WIN_W-1:0]  double_win = DOUBLE_WINDOW_RESET;
    logic [TIME_W-1:0] now_ms     = '0;
    t_ident            hist_ident [HDEPTH];
    logic [TIME_W-1:0] hist_stamp [HDEPTH];
    int unsigned       hist_head  = 0;
    int unsigned       hist_count = 0;
    bit                pend_valid = 1'b0;
    t_ident            pend_ident = '0;
    logic [TIME_W-1:0] pend_stamp = '0;

    t_out_req    expected_taps[$];
    t_step       plan[$];
    bit          typed_flag  = 1'b0;
    t_out_req    typed_want  = '0;
    bit          calm        = 1'b0;
    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;
    t_ident      pool[8];
    int          pool_size   = 1;
    t_in_req     last_key    = KEY_ZERO;
    bit          pred_has;
    t_out_req    pred_tap;
    t_out_req    want_tap;

    key_double_tap_detector #(
        .HISTORY_DEPTH(HDEPTH),
        .HISTORY_TRIM (HTRIM)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_ident ident_of(t_in_req req);
        return {req.virtual_key, req.scan_code, req.modifier_bits};
    endfunction

    function automatic t_out_req make_tap(logic tap, t_ident id, logic [TIME_W-1:0] gap);
        return {tap, id.virtual_key, id.scan_code, id.modifier_bits, gap};
    endfunction

    task automatic expire_pending(inout bit has, inout t_out_req res);
        if (pend_valid && (now_ms - pend_stamp) >= {16'h0, delay_win}) begin
            res        = make_tap(TAP_SINGLE, pend_ident, '0);
            has        = 1'b1;
            pend_valid = 1'b0;
        end
    endtask

    task automatic predict_tap(input t_in_req req, output bit has, output t_out_req res);
        t_ident            id;
        logic [TIME_W-1:0] gap;
        bit                found;
        int unsigned       slot;
        has = 1'b0;
        res = '0;
        id  = ident_of(req);
        if (req.kind == KIND_TICK) begin
            now_ms = now_ms + 1;
            if (delay_en) begin
                expire_pending(has, res);
            end
            return;
        end
        if (delay_en) begin
            expire_pending(has, res);
            if (pend_valid) begin
                gap = now_ms - pend_stamp;
                if (pend_ident == id && gap <= {16'h0, delay_win}) begin
                    res        = make_tap(TAP_DOUBLE, id, gap);
                    pend_valid = 1'b0;
                end else begin
                    res        = make_tap(TAP_SINGLE, pend_ident, '0);
                    pend_ident = id;
                    pend_stamp = now_ms;
                end
                has = 1'b1;
            end else begin
                pend_valid = 1'b1;
                pend_ident = id;
                pend_stamp = now_ms;
            end
        end else begin
            found = 1'b0;
            gap   = '0;
            for (int k = 1; k <= hist_count && !found; k++) begin
                slot = (hist_head + HDEPTH - k) % HDEPTH;
                if (hist_ident[slot] == id) begin
                    found = 1'b1;
                    gap   = now_ms - hist_stamp[slot];
                end
            end
            if (found && gap <= {16'h0, double_win}) begin
                res = make_tap(TAP_DOUBLE, id, gap);
            end else begin
                res = make_tap(TAP_SINGLE, id, '0);
            end
            has = 1'b1;
        end
        // A full history drops its oldest entries before the new tap goes in.
        if (hist_count >= HDEPTH) begin
            hist_count = (HTRIM >= HDEPTH) ? 0 : hist_count - HTRIM;
        end
        hist_ident[hist_head] = id;
        hist_stamp[hist_head] = now_ms;
        hist_head  = (hist_head + 1) % HDEPTH;
        hist_count = hist_count + 1;
    endtask

    task automatic report_mismatch(string msg);
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_taps.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_out));
                end else begin
                    want_tap = expected_taps.pop_front();
                    if (o_out.tap_type !== want_tap.tap_type)
                        report_mismatch($sformatf("tap_type %h, expected %h",
                                                  o_out.tap_type, want_tap.tap_type));
                    if (o_out.out_key !== want_tap.out_key)
                        report_mismatch($sformatf("out_key %h, expected %h",
                                                  o_out.out_key, want_tap.out_key));
                    if (o_out.out_scan !== want_tap.out_scan)
                        report_mismatch($sformatf("out_scan %h, expected %h",
                                                  o_out.out_scan, want_tap.out_scan));
                    if (o_out.out_modifiers !== want_tap.out_modifiers)
                        report_mismatch($sformatf("out_modifiers %h, expected %h",
                                                  o_out.out_modifiers,
                                                  want_tap.out_modifiers));
                    if (o_out.interval_ms !== want_tap.interval_ms)
                        report_mismatch($sformatf("interval_ms %0d, expected %0d",
                                                  o_out.interval_ms, want_tap.interval_ms));
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DELAY_ENABLE:     delay_en   = i_cfg_data[0];
                    CFG_DELAY_WINDOW_MS:  delay_win  = i_cfg_data;
                    CFG_DOUBLE_WINDOW_MS: double_win = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                predict_tap(i_in, pred_has, pred_tap);
                if (typed_flag) begin
                    expected_taps.insert(expected_taps.size(), typed_want);
                end else if (pred_has) begin
                    expected_taps.insert(expected_taps.size(), pred_tap);
                end
            end
        end
    end

    task automatic send_item(t_in_req req, bit typed, t_out_req want);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= req;
        typed_flag <= typed;
        typed_want <= want;
        do @(posedge i_clk); while (!o_in_ready);
        if (!calm && $urandom_range(0, 99) < 37) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_step cfg_step(logic [CFG_IDX_W-1:0] idx, logic [WIN_W-1:0] data);
        t_step s;
        s.is_cfg    = 1'b1;
        s.cfg_index = idx;
        s.cfg_data  = data;
        s.req       = '0;
        s.typed     = 1'b0;
        s.want      = '0;
        return s;
    endfunction

    function automatic t_step tap_step(t_in_req req, bit typed = 1'b0,
                                       logic tap = TAP_SINGLE, t_in_req of = KEY_ZERO,
                                       logic [TIME_W-1:0] gap = '0);
        t_step s;
        s.is_cfg    = 1'b0;
        s.cfg_index = CFG_DELAY_ENABLE;
        s.cfg_data  = '0;
        s.req       = req;
        s.typed     = typed;
        s.want      = make_tap(tap, ident_of(of), gap);
        return s;
    endfunction

    function automatic t_in_req random_item();
        t_in_req     r;
        int unsigned pick;
        pick            = $urandom_range(0, 99);
        r.kind          = KIND_KEY;
        r.virtual_key   = 16'($urandom_range(0, 65535));
        r.scan_code     = 16'($urandom_range(0, 65535));
        r.modifier_bits = 5'($urandom_range(0, 31));
        if (pick < 35) begin
            r.kind = KIND_TICK;
        end else if (pick < 55) begin
            r = last_key;
        end else if (pick < 90) begin
            {r.virtual_key, r.scan_code, r.modifier_bits} = pool[$urandom_range(0, pool_size - 1)];
        end
        if (r.kind == KIND_KEY) begin
            last_key = r;
        end
        return r;
    endfunction

    initial begin
        t_step s;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        plan.insert(plan.size(), tap_step(KEY_ZERO, 1'b1, TAP_SINGLE, KEY_ZERO, 0));
        plan.insert(plan.size(), tap_step(KEY_ZERO, 1'b1, TAP_DOUBLE, KEY_ZERO, 0));
        plan.insert(plan.size(), tap_step(KEY_ONES, 1'b1, TAP_SINGLE, KEY_ONES, 0));
        plan.insert(plan.size(), tap_step(TICK));
        plan.insert(plan.size(), tap_step(KEY_ZERO, 1'b1, TAP_DOUBLE, KEY_ZERO, 1));
        plan.insert(plan.size(), tap_step(KEY_MOD1, 1'b1, TAP_SINGLE, KEY_MOD1, 0));
        plan.insert(plan.size(), cfg_step(CFG_DOUBLE_WINDOW_MS, 16'h0000));
        plan.insert(plan.size(), tap_step(TICK));
        plan.insert(plan.size(), tap_step(KEY_ZERO, 1'b1, TAP_SINGLE, KEY_ZERO, 0));
        plan.insert(plan.size(), tap_step(KEY_ZERO, 1'b1, TAP_DOUBLE, KEY_ZERO, 0));
        plan.insert(plan.size(), cfg_step(CFG_DOUBLE_WINDOW_MS, 16'hffff));
        plan.insert(plan.size(), tap_step(KEY_ONES, 1'b1, TAP_DOUBLE, KEY_ONES, 2));
        plan.insert(plan.size(), cfg_step(CFG_DELAY_WINDOW_MS, 16'd2));
        plan.insert(plan.size(), cfg_step(CFG_DELAY_ENABLE, 16'd1));
        plan.insert(plan.size(), tap_step(KEY_ONES));
        plan.insert(plan.size(), tap_step(KEY_ONES, 1'b1, TAP_DOUBLE, KEY_ONES, 0));
        plan.insert(plan.size(), tap_step(KEY_ZERO));
        plan.insert(plan.size(), tap_step(KEY_ONES, 1'b1, TAP_SINGLE, KEY_ZERO, 0));
        plan.insert(plan.size(), tap_step(TICK));
        plan.insert(plan.size(), tap_step(TICK, 1'b1, TAP_SINGLE, KEY_ONES, 0));
        plan.insert(plan.size(), tap_step(TICK));
        plan.insert(plan.size(), cfg_step(CFG_DELAY_WINDOW_MS, 16'd0));
        plan.insert(plan.size(), tap_step(KEY_ZERO));
        plan.insert(plan.size(), tap_step(KEY_ZERO, 1'b1, TAP_SINGLE, KEY_ZERO, 0));
        plan.insert(plan.size(), tap_step(TICK, 1'b1, TAP_SINGLE, KEY_ZERO, 0));
        plan.insert(plan.size(), cfg_step(CFG_DELAY_WINDOW_MS, 16'hffff));
        plan.insert(plan.size(), tap_step(KEY_MOD1));
        plan.insert(plan.size(), cfg_step(CFG_DELAY_ENABLE, 16'd0));
        plan.insert(plan.size(), tap_step(KEY_MOD1));
        plan.insert(plan.size(), cfg_step(CFG_DELAY_ENABLE, 16'd1));
        plan.insert(plan.size(), tap_step(KEY_ONES, 1'b1, TAP_SINGLE, KEY_MOD1, 0));

        foreach (plan[i]) begin
            s = plan[i];
            if (s.is_cfg) begin
                wait_idle();
                cfg_write(s.cfg_index, s.cfg_data);
            end else begin
                send_item(s.req, s.typed, s.want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            calm = (ph == 1);
            case (ph)
                0: begin
                    cfg_write(CFG_DELAY_ENABLE, 16'd0);
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'd0);
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'hffff);
                end
                1: begin
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'($urandom_range(0, 65535)));
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'($urandom_range(0, 6)));
                end
                2: begin
                    cfg_write(CFG_DELAY_ENABLE, 16'd1);
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'd0);
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'd0);
                end
                3: begin
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'hffff);
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'($urandom_range(0, 65535)));
                end
                4: begin
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'($urandom_range(1, 5)));
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'd0);
                end
                5: begin
                    cfg_write(CFG_DELAY_ENABLE, 16'd0);
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'($urandom_range(0, 65535)));
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'($urandom_range(0, 3)));
                end
                6: begin
                    cfg_write(CFG_DELAY_ENABLE, 16'd1);
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'($urandom_range(0, 3)));
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'($urandom_range(0, 10)));
                end
                default: begin
                    cfg_write(CFG_DELAY_ENABLE, 16'd0);
                    cfg_write(CFG_DELAY_WINDOW_MS, 16'($urandom_range(0, 65535)));
                    cfg_write(CFG_DOUBLE_WINDOW_MS, 16'($urandom_range(0, 12)));
                end
            endcase
            pool_size = $urandom_range(2, 8);
            foreach (pool[j]) begin
                pool[j] = {16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           5'($urandom_range(0, 31))};
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_item(random_item(), 1'b0, '0);
            end
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
